FILE: hdl/tal_annotation_parser_defines.svh
// Assertion macros for the annotation parser
`ifndef TAL_ANNOTATION_PARSER_DEFINES_SVH
`define TAL_ANNOTATION_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TAP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tap: check failed");

// next-cycle implication, checked out of reset
`define TAP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tap: check failed");

`endif

FILE: hdl/tap_pkg.sv
package tap_pkg;

  localparam int ONSET_MAX_DEF = 63;
  localparam int TEXT_MAX_DEF  = 255;

  localparam logic [1:0] KIND_ONSET = 2'd0;
  localparam logic [1:0] KIND_TEXT  = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  localparam logic [7:0] SEP_BYTE   = 8'd20;
  localparam logic [7:0] SIGN_PLUS  = 8'h2B;
  localparam logic [7:0] SIGN_MINUS = 8'h2D;

  typedef struct packed {
    logic take;
    logic flush_start;
    logic flush_step;
    logic pend_emit;
  } tap_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic need_flush;
    logic flush_done;
  } tap_sts_t;

endpackage

FILE: hdl/tap_ctrl.sv
module tap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tap_pkg::tap_sts_t sts,
  output tap_pkg::tap_cmd_t cmd
);
  import tap_pkg::*;

  localparam logic [1:0] S_RUN   = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_TAIL  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    cmd.take        = 1'b0;
    cmd.flush_start = 1'b0;
    cmd.flush_step  = 1'b0;
    cmd.pend_emit   = 1'b0;
    case (state_r)
      S_RUN: begin
        in_ready        = sts.slot_free;
        cmd.take        = in_valid && sts.slot_free;
        cmd.flush_start = cmd.take && sts.need_flush;
        if (cmd.flush_start) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd.flush_step = sts.slot_free;
        if (sts.slot_free && sts.flush_done) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.pend_emit = sts.slot_free;
        if (sts.slot_free) begin
          state_nxt = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/tap_datapath.sv
module tap_datapath #(
  parameter int ONSET_MAX = tap_pkg::ONSET_MAX_DEF,
  parameter int TEXT_MAX  = tap_pkg::TEXT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data_byte,
  input  logic              in_block_last,
  input  tap_pkg::tap_cmd_t cmd,
  output tap_pkg::tap_sts_t sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_byte_value,
  output logic              out_text_end,
  output logic              out_annotation_end,
  output logic              out_run_last
);
  import tap_pkg::*;

  localparam int OL_W = $clog2(ONSET_MAX + 1);
  localparam int AW   = $clog2(ONSET_MAX);
  localparam int TL_W = $clog2(TEXT_MAX);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ONSET = 2'd1;
  localparam logic [1:0] MODE_TEXT  = 2'd2;

  logic [7:0]      onset_mem [ONSET_MAX];

  logic [1:0]      mode_r, mode_nxt;
  logic [OL_W-1:0] onset_len_r, onset_len_nxt;
  logic [TL_W-1:0] text_len_r, text_len_nxt;
  logic            has_text_r, has_text_nxt;

  logic [AW-1:0]   idx_r;
  logic [7:0]      rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            rd_en;

  logic [7:0]      pend_byte_r;
  logic            pend_tend_r;
  logic            pend_aend_r;

  logic            out_valid_r;
  logic [1:0]      kind_r;
  logic [7:0]      byte_r;
  logic            tend_r;
  logic            aend_r;
  logic            rlast_r;

  logic            is_sign, is_sep, is_zero, regular, close;
  logic [TL_W:0]   tl_inc;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            tend, aend, emit, need_flush;
  logic [1:0]      kind_d;
  logic [7:0]      byte_d;
  logic            slot_free;
  logic            flush_done;

  assign is_sign = (in_data_byte == SIGN_PLUS) || (in_data_byte == SIGN_MINUS);
  assign is_sep  = (in_data_byte == SEP_BYTE);
  assign is_zero = (in_data_byte == 8'd0);
  assign regular = !is_zero && !is_sep;
  assign close   = is_zero || in_block_last;
  assign tl_inc  = {1'b0, text_len_r} + (TL_W + 1)'(1);

  always_comb begin
    mode_nxt      = mode_r;
    onset_len_nxt = onset_len_r;
    text_len_nxt  = text_len_r;
    has_text_nxt  = has_text_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    tend          = 1'b0;
    aend          = 1'b0;
    emit          = 1'b0;
    need_flush    = 1'b0;
    kind_d        = KIND_MARK;
    byte_d        = 8'd0;
    case (mode_r)
      MODE_IDLE: begin
        if (is_sign) begin
          wr_en         = 1'b1;
          onset_len_nxt = OL_W'(1);
          mode_nxt      = MODE_ONSET;
        end
      end
      MODE_ONSET: begin
        if (is_sep) begin
          mode_nxt     = MODE_TEXT;
          text_len_nxt = '0;
          has_text_nxt = 1'b0;
        end else if (onset_len_r < OL_W'(ONSET_MAX)) begin
          wr_en         = 1'b1;
          wr_addr       = onset_len_r[AW-1:0];
          onset_len_nxt = onset_len_r + OL_W'(1);
        end
      end
      MODE_TEXT: begin
        if (regular) begin
          need_flush   = !has_text_r;
          has_text_nxt = 1'b1;
          if (tl_inc >= (TL_W + 1)'(TEXT_MAX)) begin
            tend         = 1'b1;
            text_len_nxt = '0;
          end else begin
            text_len_nxt = tl_inc[TL_W-1:0];
          end
        end else if (text_len_r != '0) begin
          tend         = 1'b1;
          text_len_nxt = '0;
        end
        if (close && (text_len_nxt != '0)) begin
          tend         = 1'b1;
          text_len_nxt = '0;
        end
        aend   = close && has_text_nxt;
        emit   = regular || tend || aend;
        kind_d = regular ? KIND_TEXT : KIND_MARK;
        byte_d = regular ? in_data_byte : 8'd0;
        if (close) begin
          mode_nxt     = MODE_IDLE;
          text_len_nxt = '0;
          has_text_nxt = 1'b0;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
    if (in_block_last) begin
      mode_nxt     = MODE_IDLE;
      text_len_nxt = '0;
      has_text_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      onset_len_r <= '0;
      text_len_r  <= '0;
      has_text_r  <= 1'b0;
    end else if (cmd.take) begin
      mode_r      <= mode_nxt;
      onset_len_r <= onset_len_nxt;
      text_len_r  <= text_len_nxt;
      has_text_r  <= has_text_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && wr_en) begin
      onset_mem[wr_addr] <= in_data_byte;
    end
  end

  assign flush_done = (OL_W'(idx_r) + OL_W'(1)) == onset_len_r;
  assign rd_addr    = cmd.flush_start ? '0 : idx_r + AW'(1);
  assign rd_en      = cmd.flush_start || (cmd.flush_step && !flush_done);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= onset_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      idx_r <= '0;
    end else if (cmd.flush_step) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_byte_r <= in_data_byte;
      pend_tend_r <= tend;
      pend_aend_r <= aend;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take && emit && !need_flush) begin
      kind_r  <= kind_d;
      byte_r  <= byte_d;
      tend_r  <= tend;
      aend_r  <= aend;
      rlast_r <= 1'b1;
    end else if (cmd.flush_step) begin
      kind_r  <= KIND_ONSET;
      byte_r  <= rd_data_r;
      tend_r  <= 1'b0;
      aend_r  <= 1'b0;
      rlast_r <= 1'b0;
    end else if (cmd.pend_emit) begin
      kind_r  <= KIND_TEXT;
      byte_r  <= pend_byte_r;
      tend_r  <= pend_tend_r;
      aend_r  <= pend_aend_r;
      rlast_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.take && emit && !need_flush) || cmd.flush_step || cmd.pend_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.slot_free  = slot_free;
  assign sts.need_flush = need_flush;
  assign sts.flush_done = flush_done;

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_byte_value     = byte_r;
  assign out_text_end       = tend_r;
  assign out_annotation_end = aend_r;
  assign out_run_last       = rlast_r;

endmodule

FILE: hdl/tal_annotation_parser.sv
// A text byte or marker other than an annotation's first text byte is registered when taken.
// Throughput: 1 input beat per cycle outside onset flushes while the output takes beats.
// The first text byte of an annotation holds the input while its onset goes out: one onset
// store read, one onset byte per cycle while the output is free, then the text byte itself.
// Reset: synchronous, active low; clears parser mode, lengths, flags and output valid.
// The onset store is not cleared; only entries written in the current annotation are read.
module tal_annotation_parser #(
  parameter int ONSET_MAX = tap_pkg::ONSET_MAX_DEF,
  parameter int TEXT_MAX  = tap_pkg::TEXT_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_block_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte_value,
  output logic       out_text_end,
  output logic       out_annotation_end,
  output logic       out_run_last
);
  import tap_pkg::*;

  tap_cmd_t cmd;
  tap_sts_t sts;

  tap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tap_datapath #(
    .ONSET_MAX (ONSET_MAX),
    .TEXT_MAX  (TEXT_MAX)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_data_byte       (in_data_byte),
    .in_block_last      (in_block_last),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_byte_value     (out_byte_value),
    .out_text_end       (out_text_end),
    .out_annotation_end (out_annotation_end),
    .out_run_last       (out_run_last)
  );

`include "tal_annotation_parser_defines.svh"

  `TAP_ASSERT_IMP(a_no_take_while_busy, cmd.flush_step || cmd.pend_emit, !in_ready)
  `TAP_ASSERT_NXT(a_flush_blocks_input, cmd.flush_start, !in_ready && !cmd.pend_emit)
  `TAP_ASSERT_IMP(a_onset_beat_plain, out_valid && (out_kind == KIND_ONSET), !out_run_last && !out_text_end && !out_annotation_end)
  `TAP_ASSERT_NXT(a_tail_is_text, cmd.pend_emit, out_valid && (out_kind == KIND_TEXT) && out_run_last)

endmodule
